// ===== rtl/hbw_pkg.sv =====
// Shared types and constants for the heartbeat watchdog block.
// Used by the top level and the millisecond divider; no dependencies.
package hbw_pkg;

   // Field widths of the item and result payloads.
   localparam int KIND_W   = 3;
   localparam int CH_W     = 3;
   localparam int NOW_W    = 52;
   localparam int MS_W     = 32;
   localparam int EV_W     = 1;
   localparam int CFG_W    = 20;
   localparam int CSR_IDX_W = 2;

   // Stream bus widths: channel then now_us, channel_res then elapsed_ms.
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;

   localparam int CHANNELS_DEFAULT = 8;

   // Time scaling.
   localparam int US_PER_MS   = 1000;
   localparam int SLOW_FACTOR = 7;

   // Wide enough for response_timeout_ms * 7000 microseconds.
   localparam int TMO_W = 33;
   localparam logic [TMO_W-1:0] FAST_US = TMO_W'(US_PER_MS);
   localparam logic [TMO_W-1:0] SLOW_US = TMO_W'(US_PER_MS * SLOW_FACTOR);

   // Register reset values.
   localparam logic [CFG_W-1:0] RESPONSE_TIMEOUT_RESET = CFG_W'(10000);
   localparam logic [CFG_W-1:0] CHECK_INTERVAL_RESET   = CFG_W'(1000);
   localparam logic             SLOW_IMAGE_RESET       = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 3'd0,
      KIND_REPLY  = 3'd1,
      KIND_PAUSE  = 3'd2,
      KIND_RESUME = 3'd3,
      KIND_STOP   = 3'd4,
      KIND_ADD    = 3'd5
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RESPONSE_TIMEOUT = 2'd0,
      REG_CHECK_INTERVAL   = 2'd1,
      REG_SLOW_IMAGE       = 2'd2
   } reg_index_type;

   localparam logic [EV_W-1:0] EV_PING = 1'b0;
   localparam logic [EV_W-1:0] EV_HANG = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0] channel_res;
      logic [EV_W-1:0] event_res;
      logic [MS_W-1:0] elapsed_ms;
   } result_type;

endpackage

// ===== rtl/hbw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; width and depth come from parameters.
module hbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hbw_div.sv =====
// Divider by one thousand that turns a microsecond span into saturated
// milliseconds by reciprocal multiplication. Uses hbw_pkg.
module hbw_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [hbw_pkg::NOW_W-1:0] dividend,
   output logic                     done,
   output logic [hbw_pkg::MS_W-1:0]  quotient_ms
);

   localparam int NW    = hbw_pkg::NOW_W;
   localparam int MW    = hbw_pkg::MS_W;
   localparam int YW    = 39;
   localparam int HW    = 20;
   localparam int ACC_W = 4 * HW;
   localparam int SHIFT = 46;
   localparam int STEPS = 4;
   localparam int CNT_W = 3;
   // Ceiling of 2^46 / 125; exact for every dividend / 8 below 2^39.
   localparam logic [2*HW-1:0] RECIP = 40'd562949953422;

   logic [YW-1:0]    y_ff,   y_in;
   logic             sat_ff, sat_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [HW-1:0]    op_y;
   logic [HW-1:0]    op_m;
   logic [2*HW-1:0]  part;
   logic [ACC_W-1:0] part_shifted;

   // One 20 by 20 partial product per cycle is added into the accumulator;
   // the quotient is the product of dividend / 8 and the reciprocal of 125.
   always_comb begin
      case (cnt_ff)
         CNT_W'(4): begin
            op_y = y_ff[HW-1:0];
            op_m = RECIP[HW-1:0];
         end
         CNT_W'(3): begin
            op_y = y_ff[HW-1:0];
            op_m = RECIP[2*HW-1:HW];
         end
         CNT_W'(2): begin
            op_y = {1'b0, y_ff[YW-1:HW]};
            op_m = RECIP[HW-1:0];
         end
         default: begin
            op_y = {1'b0, y_ff[YW-1:HW]};
            op_m = RECIP[2*HW-1:HW];
         end
      endcase
      part = (2*HW)'(op_y) * (2*HW)'(op_m);
      case (cnt_ff)
         CNT_W'(4): part_shifted = {(2*HW)'(0), part};
         CNT_W'(1): part_shifted = {part, (2*HW)'(0)};
         default:   part_shifted = {HW'(0), part, HW'(0)};
      endcase

      y_in    = y_ff;
      sat_in  = sat_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         y_in    = dividend[YW+2:3];
         sat_in  = |dividend[NW-1:YW+3];
         acc_in  = '0;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part_shifted;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      y_ff   <= y_in;
      sat_ff <= sat_in;
      acc_ff <= acc_in;
   end

   assign done        = done_ff;
   assign quotient_ms = (sat_ff || acc_ff[SHIFT+MW]) ? '1 : acc_ff[SHIFT+MW-1:SHIFT];

endmodule

// ===== rtl/multi_channel_heartbeat_watchdog.sv =====
// Heartbeat watchdog over up to CHANNELS channels; check times live in one RAM.
// Reply, resume, ignored items and adds that do not ping finish in the idle state; a pinging
// add also passes the flush state. Pause and stop sweep a RAM write over every active channel.
// A running tick reads and compares each active channel, pushes a result per ping and runs the
// reciprocal divider per hang; a full result register can stall it. One item at a time.
// Synchronous reset clears flags, pending bits and channel count and loads register defaults.
module multi_channel_heartbeat_watchdog #(
   parameter int CHANNELS = hbw_pkg::CHANNELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: channel [2:0], now_us [54:3], zero pad [55]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hbw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: kind [2:0]
   input  logic [hbw_pkg::KIND_W-1:0]         req_tuser,
   // rsp_tdata: channel_res [2:0], elapsed_ms [34:3], zero pad [39:35]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hbw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: event_res [0]
   output logic [hbw_pkg::EV_W-1:0]           rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hbw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hbw_pkg::CFG_W-1:0]          csr_data
);

   localparam int IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int NW    = hbw_pkg::NOW_W;
   localparam int TW    = hbw_pkg::TMO_W;
   localparam int CW    = hbw_pkg::CH_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_EVAL,
      ST_DIV,
      ST_PUSH,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         in_use_ff, in_use_in;
   logic                     paused_ff, paused_in;
   logic                     stopped_ff, stopped_in;
   logic [CHANNELS-1:0]      pending_ff, pending_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic [NW-1:0]            now_ff, now_in;
   logic [TW-1:0]            tmo_ff, tmo_in;
   logic [TW-1:0]            ivl_ff, ivl_in;
   logic [hbw_pkg::CFG_W-1:0] cfg_resp_ff, cfg_resp_in;
   logic [hbw_pkg::CFG_W-1:0] cfg_ivl_ff, cfg_ivl_in;
   logic                     cfg_slow_ff, cfg_slow_in;
   logic                     hold_valid_ff, hold_valid_in;
   hbw_pkg::result_type      hold_ff, hold_in;
   hbw_pkg::result_type      new_ff, new_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   hbw_pkg::result_type      rsp_res_ff, rsp_res_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     ram_we;
   logic [IW-1:0]            ram_waddr;
   logic [NW-1:0]            ram_wdata;
   logic                     ram_re;
   logic [NW-1:0]            ram_rdata;

   logic                     div_start;
   logic [NW-1:0]            div_dividend;
   logic                     div_done;
   logic [hbw_pkg::MS_W-1:0] div_ms;

   logic                     out_free;
   logic                     last_ch;
   logic                     hang;
   logic                     ping;
   logic                     add_active;
   logic [CW-1:0]            req_channel;
   logic [NW-1:0]            req_now;
   hbw_pkg::kind_type        req_kind;

   assign req_channel = req_tdata[CW-1:0];
   assign req_now     = req_tdata[CW+NW-1:CW];
   assign req_kind    = hbw_pkg::kind_type'(req_tuser);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_ch    = (CNT_W'(idx_ff) + CNT_W'(1)) == in_use_ff;
   assign add_active = !paused_ff && !stopped_ff;

   // A RAM entry is read once per sweep and written back only after its own
   // read, so no two accesses to one entry overlap.
   assign hang = pending_ff[idx_ff] &&
                 ({1'b0, now_ff} > ({1'b0, ram_rdata} + (NW + 1)'(tmo_ff)));
   assign ping = !pending_ff[idx_ff] &&
                 ({1'b0, now_ff} > ({1'b0, ram_rdata} + (NW + 1)'(ivl_ff)));

   always_comb begin
      state_in      = state_ff;
      in_use_in     = in_use_ff;
      paused_in     = paused_ff;
      stopped_in    = stopped_ff;
      pending_in    = pending_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      tmo_in        = tmo_ff;
      ivl_in        = ivl_ff;
      cfg_resp_in   = cfg_resp_ff;
      cfg_ivl_in    = cfg_ivl_ff;
      cfg_slow_in   = cfg_slow_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = now_ff;
      ram_re        = 1'b0;
      div_start     = 1'b0;
      div_dividend  = now_ff - ram_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in = req_now;
               idx_in = '0;
               tmo_in = cfg_slow_ff ? TW'(cfg_resp_ff) * hbw_pkg::SLOW_US
                                    : TW'(cfg_resp_ff) * hbw_pkg::FAST_US;
               ivl_in = TW'(cfg_ivl_ff) * hbw_pkg::FAST_US;
               case (req_kind)
                  hbw_pkg::KIND_TICK: begin
                     if (add_active && in_use_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  hbw_pkg::KIND_REPLY: begin
                     if (32'(req_channel) < 32'(in_use_ff)) begin
                        pending_in[IW'(req_channel)] = 1'b0;
                     end
                  end
                  hbw_pkg::KIND_PAUSE: begin
                     paused_in  = 1'b1;
                     pending_in = '0;
                     if (in_use_ff != '0) begin
                        state_in = ST_SWEEP;
                     end
                  end
                  hbw_pkg::KIND_RESUME: begin
                     paused_in = 1'b0;
                  end
                  hbw_pkg::KIND_STOP: begin
                     stopped_in = 1'b1;
                     pending_in = '0;
                     if (in_use_ff != '0) begin
                        state_in = ST_SWEEP;
                     end
                  end
                  hbw_pkg::KIND_ADD: begin
                     if (32'(in_use_ff) < CHANNELS) begin
                        in_use_in = in_use_ff + CNT_W'(1);
                        ram_we    = 1'b1;
                        ram_waddr = IW'(in_use_ff);
                        ram_wdata = add_active ? req_now : '0;
                        pending_in[IW'(in_use_ff)] = add_active;
                        if (add_active) begin
                           hold_valid_in       = 1'b1;
                           hold_in.channel_res = CW'(in_use_ff);
                           hold_in.event_res   = hbw_pkg::EV_PING;
                           hold_in.elapsed_ms  = '0;
                           state_in            = ST_FLUSH;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            ram_we = 1'b1;
            if (last_ch) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end

         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            if (hang) begin
               div_start          = 1'b1;
               new_in.channel_res = CW'(idx_ff);
               new_in.event_res   = hbw_pkg::EV_HANG;
               new_in.elapsed_ms  = '0;
               state_in           = ST_DIV;
            end else if (ping) begin
               ram_we              = 1'b1;
               pending_in[idx_ff]  = 1'b1;
               new_in.channel_res  = CW'(idx_ff);
               new_in.event_res    = hbw_pkg::EV_PING;
               new_in.elapsed_ms   = '0;
               state_in            = ST_PUSH;
            end else if (last_ch) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_READ;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               new_in.elapsed_ms = div_ms;
               state_in          = ST_PUSH;
            end
         end

         // One result is held back so that the final one of a tick can be
         // marked as last once the sweep is over.
         ST_PUSH: begin
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_res_in   = hold_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_in       = new_ff;
               hold_valid_in = 1'b1;
               if (last_ch) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_READ;
               end
            end
         end

         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_res_in    = hold_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (hbw_pkg::reg_index_type'(csr_index))
            hbw_pkg::REG_RESPONSE_TIMEOUT: cfg_resp_in = csr_data;
            hbw_pkg::REG_CHECK_INTERVAL:   cfg_ivl_in  = csr_data;
            hbw_pkg::REG_SLOW_IMAGE:       cfg_slow_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_use_ff     <= '0;
         paused_ff     <= 1'b0;
         stopped_ff    <= 1'b0;
         pending_ff    <= '0;
         cfg_resp_ff   <= hbw_pkg::RESPONSE_TIMEOUT_RESET;
         cfg_ivl_ff    <= hbw_pkg::CHECK_INTERVAL_RESET;
         cfg_slow_ff   <= hbw_pkg::SLOW_IMAGE_RESET;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         paused_ff     <= paused_in;
         stopped_ff    <= stopped_in;
         pending_ff    <= pending_in;
         cfg_resp_ff   <= cfg_resp_in;
         cfg_ivl_ff    <= cfg_ivl_in;
         cfg_slow_ff   <= cfg_slow_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      tmo_ff      <= tmo_in;
      ivl_ff      <= ivl_in;
      hold_ff     <= hold_in;
      new_ff      <= new_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   hbw_ram #(
      .WIDTH (NW),
      .DEPTH (CHANNELS)
   ) u_check_time_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   hbw_div u_ms_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .done        (div_done),
      .quotient_ms (div_ms)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(hbw_pkg::RSP_TDATA_W - CW - hbw_pkg::MS_W)'(0),
                        rsp_res_ff.elapsed_ms, rsp_res_ff.channel_res};
   assign rsp_tuser  = rsp_res_ff.event_res;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for multi_channel_heartbeat_watchdog: drives items on the request
// stream, predicts pings and hang reports per channel, and checks every result item.
// Depends on hbw_pkg and the watchdog top level only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hbw_pkg::*;

   localparam int NCH           = CHANNELS_DEFAULT;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT   = 600000;
   localparam logic [NOW_W-1:0] NOW_MAX = '1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [EV_W-1:0]        rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_ready;

   multi_channel_heartbeat_watchdog #(.CHANNELS(NCH)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   typedef struct {
      logic [CH_W-1:0] ch;
      logic [EV_W-1:0] ev;
      logic [MS_W-1:0] ms;
      logic            last;
   } report_type;

   report_type due_reports[$];
   int      fail_count  = 0;
   int      burst_left  = 0;
   int      stall_left  = 0;
   bit [31:0] cycle_count = '0;

   // Shadow copy of the watchdog state and its registers.
   bit               wd_pending[NCH];
   logic [NOW_W-1:0] wd_check_us[NCH];
   int               wd_active;
   bit               wd_paused;
   bit               wd_stopped;
   logic [CFG_W-1:0] wd_timeout_ms;
   logic [CFG_W-1:0] wd_interval_ms;
   bit               wd_slow;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver back-pressure: the pattern is chosen by bits 9:8 of the cycle count.
   always @(posedge clock) begin
      case (cycle_count[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(1, 0));
         2'd2: rsp_tready <= (cycle_count[2:0] < 3'd2);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else if ($urandom_range(7, 0) == 0) begin
               stall_left = $urandom_range(15, 3);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_reports.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual ch %0d ev %0d ms %0d",
                     $time, rsp_tdata[2:0], rsp_tuser, rsp_tdata[34:3]);
            fail_count++;
         end else begin
            want = due_reports.pop_front();
            check_field("channel_res", 64'(want.ch), 64'(rsp_tdata[2:0]));
            check_field("event_res", 64'(want.ev), 64'(rsp_tuser));
            check_field("elapsed_ms", 64'(want.ms), 64'(rsp_tdata[34:3]));
            check_field("last", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   // Updates the shadow state for one accepted item and queues the results it causes.
   function automatic void watchdog_predict(logic [KIND_W-1:0] kind, logic [CH_W-1:0] ch,
                                            logic [NOW_W-1:0] now);
      report_type  batch[$];
      report_type  r;
      logic [63:0] tmo;
      logic [63:0] ivl;
      logic [63:0] ms;
      int          c;
      tmo = 64'(wd_timeout_ms) * 64'(US_PER_MS);
      if (wd_slow)
         tmo = tmo * 64'(SLOW_FACTOR);
      ivl = 64'(wd_interval_ms) * 64'(US_PER_MS);
      r.last = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (!wd_paused && !wd_stopped) begin
               for (int i = 0; i < wd_active; i++) begin
                  r.ch = CH_W'(i);
                  if (wd_pending[i]) begin
                     if (64'(now) > 64'(wd_check_us[i]) + tmo) begin
                        ms = (64'(now) - 64'(wd_check_us[i])) / 64'(US_PER_MS);
                        if (ms > 64'hFFFF_FFFF)
                           ms = 64'hFFFF_FFFF;
                        r.ev = EV_HANG;
                        r.ms = ms[MS_W-1:0];
                        batch.push_back(r);
                     end
                  end else if (64'(now) > 64'(wd_check_us[i]) + ivl) begin
                     wd_pending[i]  = 1'b1;
                     wd_check_us[i] = now;
                     r.ev = EV_PING;
                     r.ms = '0;
                     batch.push_back(r);
                  end
               end
            end
         end
         KIND_REPLY: begin
            if (ch < wd_active)
               wd_pending[ch] = 1'b0;
         end
         KIND_PAUSE, KIND_STOP: begin
            for (int i = 0; i < wd_active; i++) begin
               wd_pending[i]  = 1'b0;
               wd_check_us[i] = now;
            end
            if (kind == KIND_PAUSE)
               wd_paused = 1'b1;
            else
               wd_stopped = 1'b1;
         end
         KIND_RESUME: wd_paused = 1'b0;
         KIND_ADD: begin
            if (wd_active < NCH) begin
               c = wd_active;
               wd_active++;
               wd_pending[c]  = 1'b0;
               wd_check_us[c] = '0;
               if (!wd_paused && !wd_stopped) begin
                  wd_pending[c]  = 1'b1;
                  wd_check_us[c] = now;
                  r.ch = CH_W'(c);
                  r.ev = EV_PING;
                  r.ms = '0;
                  batch.push_back(r);
               end
            end
         end
         default: ;
      endcase
      if (batch.size() > 0)
         batch[batch.size()-1].last = 1'b1;
      foreach (batch[i])
         due_reports.push_back(batch[i]);
   endfunction

   // Sends one item; the sender runs in bursts with idle gaps between them.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                            input logic [NOW_W-1:0] now);
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 20)
                                                   : $urandom_range(8, 1);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, now, ch};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      watchdog_predict(kind, ch, now);
   endtask

   // Holds off the sender until every predicted result has arrived, then lets the block settle.
   task automatic drain_results;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_RESPONSE_TIMEOUT: wd_timeout_ms  = value;
         REG_CHECK_INTERVAL:   wd_interval_ms = value;
         REG_SLOW_IMAGE:       wd_slow        = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [CFG_W-1:0] tmo_ms, input logic [CFG_W-1:0] ivl_ms,
                             input bit slow);
      drain_results();
      write_reg(REG_RESPONSE_TIMEOUT, tmo_ms);
      write_reg(REG_CHECK_INTERVAL, ivl_ms);
      write_reg(REG_SLOW_IMAGE, CFG_W'(slow));
   endtask

   // Default registers, elapsed-time saturation, stray replies and unknown kinds.
   task automatic test_defaults_and_saturation;
      send_item(KIND_ADD, 3'd0, '0);
      send_item(KIND_TICK, 3'd7, NOW_MAX);
      send_item(KIND_REPLY, 3'd0, NOW_MAX);
      send_item(KIND_REPLY, 3'd7, NOW_MAX);
      send_item(3'd6, 3'd5, NOW_W'({$urandom, $urandom}));
      send_item(3'd7, 3'd2, NOW_W'({$urandom, $urandom}));
      send_item(KIND_TICK, 3'd0, NOW_MAX);
      send_item(KIND_TICK, 3'd0, NOW_MAX);
   endtask

   task automatic test_pause_resume;
      logic [NOW_W-1:0] t;
      send_item(KIND_PAUSE, 3'd0, NOW_W'(1000));
      send_item(KIND_TICK, 3'd0, NOW_W'(5_000_000));
      // An add while paused activates the channel with a zero check time and no ping.
      send_item(KIND_ADD, 3'd0, NOW_W'(2000));
      send_item(KIND_PAUSE, 3'd0, NOW_W'(3000));
      send_item(KIND_RESUME, 3'd0, NOW_W'(3000));
      t = NOW_W'(3000 + 1_000_001);
      send_item(KIND_TICK, 3'd0, t);
      t = t + NOW_W'(70_000_001);
      send_item(KIND_TICK, 3'd0, t);
      send_item(KIND_REPLY, 3'd1, t);
      t = t + NOW_W'(1_500_000);
      send_item(KIND_TICK, 3'd0, t);
      send_item(KIND_RESUME, 3'd0, t);
   endtask

   // Zero limits fire as soon as time passes the stamp; going backwards fires nothing.
   task automatic test_zero_limits;
      logic [NOW_W-1:0] t;
      set_limits('0, '0, 1'b0);
      t = NOW_W'(64'd5_000_000_000);
      send_item(KIND_PAUSE, 3'd0, t);
      send_item(KIND_RESUME, 3'd0, t);
      send_item(KIND_TICK, 3'd0, t);
      send_item(KIND_TICK, 3'd0, t + 1);
      send_item(KIND_TICK, 3'd0, t + 1);
      send_item(KIND_TICK, 3'd0, t + 2);
      send_item(KIND_TICK, 3'd0, t - 100);
   endtask

   task automatic test_random_traffic(input int item_goal, input logic [63:0] max_step_us,
                                      input logic [NOW_W-1:0] start_us);
      logic [NOW_W-1:0] now_us;
      logic [63:0]      step;
      logic [CH_W-1:0]  ch;
      int               done;
      int               pick;
      now_us = start_us;
      send_item(KIND_PAUSE, CH_W'($urandom), now_us);
      send_item(KIND_RESUME, CH_W'($urandom), now_us);
      done = 0;
      while (done < item_goal) begin
         pick = $urandom_range(99, 0);
         step = 64'({$urandom, $urandom}) % (max_step_us + 1);
         if (pick < 4)
            now_us = now_us - NOW_W'(step);
         else
            now_us = now_us + NOW_W'(step);
         if (pick < 45) begin
            send_item(KIND_TICK, CH_W'($urandom), now_us);
            done++;
         end else if (pick < 75) begin
            // Mostly answer a channel that is actually waiting for a reply.
            ch = CH_W'($urandom);
            for (int t = 0; t < 4 && !(ch < wd_active && wd_pending[ch]); t++)
               ch = CH_W'($urandom);
            send_item(KIND_REPLY, ch, now_us);
            if (ch < wd_active)
               done++;
         end else if (pick < 82) begin
            // One channel stays free for the add after stop.
            if (wd_active < NCH - 1) begin
               send_item(KIND_ADD, CH_W'($urandom), now_us);
               done++;
            end
         end else if (pick < 87) begin
            send_item(KIND_PAUSE, CH_W'($urandom), now_us);
            done++;
         end else if (pick < 94) begin
            send_item(KIND_RESUME, CH_W'($urandom), now_us);
            done++;
         end else begin
            send_item(KIND_W'($urandom_range(7, 6)), CH_W'($urandom),
                      NOW_W'({$urandom, $urandom}));
         end
      end
      drain_results();
   endtask

   // Stop stays in force until reset; adds after it only activate, and adds past capacity
   // are dropped.
   task automatic test_stop_final;
      logic [NOW_W-1:0] t;
      int               extra;
      t = NOW_W'(64'd9_000_000_000_000);
      send_item(KIND_STOP, 3'd0, t);
      send_item(KIND_TICK, 3'd0, NOW_MAX);
      send_item(KIND_RESUME, 3'd0, NOW_MAX);
      send_item(KIND_TICK, 3'd0, NOW_MAX);
      extra = NCH - wd_active + 2;
      for (int k = 0; k < extra; k++)
         send_item(KIND_ADD, 3'd0, t + NOW_W'(k));
      send_item(KIND_REPLY, 3'd0, t);
      send_item(KIND_STOP, 3'd0, t + 5);
      send_item(KIND_TICK, 3'd0, NOW_MAX);
   endtask

   initial begin
      for (int i = 0; i < NCH; i++) begin
         wd_pending[i]  = 1'b0;
         wd_check_us[i] = '0;
      end
      wd_active      = 0;
      wd_paused      = 1'b0;
      wd_stopped     = 1'b0;
      wd_timeout_ms  = RESPONSE_TIMEOUT_RESET;
      wd_interval_ms = CHECK_INTERVAL_RESET;
      wd_slow        = SLOW_IMAGE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults_and_saturation();
      test_pause_resume();
      test_zero_limits();

      set_limits(CFG_W'(2), CFG_W'(1), 1'b0);
      test_random_traffic(25, 64'd4000, NOW_W'(64'd1_000_000_000));
      set_limits(CFG_W'(1), CFG_W'(3), 1'b1);
      test_random_traffic(25, 64'd6000, NOW_W'(64'd2_000_000_000));
      set_limits(CFG_W'($urandom_range(50, 1)), CFG_W'($urandom_range(50, 1)),
                 1'($urandom_range(1, 0)));
      test_random_traffic(25, 64'd60000, NOW_W'(64'd3_000_000_000));
      set_limits(CFG_W'(1_000_000), CFG_W'(1_000_000), 1'b1);
      test_random_traffic(25, 64'd8_600_000_000, NOW_W'(64'h8_0000_0000_0000));
      set_limits(CFG_W'($urandom_range(1_000_000, 1)), CFG_W'($urandom_range(1_000_000, 1)),
                 1'b0);
      test_stop_final();

      drain_results();
      if (fail_count == 0 && due_reports.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
